@@ sv/cbfc_pkg.sv @@
// Shared types, widths and register codes for the chunk box frustum cull block.
// Used by the channel interfaces, the top level and the checker.
package cbfc_pkg;

    localparam int INDEX_W  = 12;   // chunk index
    localparam int COORD_W  = 24;   // world offsets and camera position
    localparam int SIZE_W   = 16;   // chunk size and max height
    localparam int ROW_W    = 64;   // one matrix row, four coefficients
    localparam int COEF_W   = 16;   // signed Q5.10 coefficient
    localparam int ROWS     = 4;
    localparam int CORNERS  = 8;
    localparam int AXIS_STEPS = 2;
    localparam int CFG_W    = 64;   // widest register

    localparam int BASE_W   = COORD_W + 1;          // offset plus camera
    localparam int PROD_W   = COEF_W + BASE_W;      // coefficient times base
    localparam int STEP_W   = COEF_W + SIZE_W + 1;  // coefficient times edge
    localparam int CLIP_W   = 46;                   // clip coordinate, exact
    localparam int CMP_W    = CLIP_W + 1;           // plane test sum

    localparam logic [SIZE_W-1:0] CHUNK_SIZE_RST = SIZE_W'(64);
    localparam logic [SIZE_W-1:0] MAX_HEIGHT_RST = SIZE_W'(256);

    typedef enum logic [2:0] {
        REG_MATRIX_ROW0 = 3'd0,
        REG_MATRIX_ROW1 = 3'd1,
        REG_MATRIX_ROW2 = 3'd2,
        REG_MATRIX_ROW3 = 3'd3,
        REG_CAMERA_X    = 3'd4,
        REG_CAMERA_Z    = 3'd5,
        REG_CHUNK_SIZE  = 3'd6,
        REG_MAX_HEIGHT  = 3'd7
    } cfg_reg_t;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [CLIP_W-1:0] clip_t;

    // Pick column col of a matrix row.
    function automatic coef_t coeff(input logic [ROW_W-1:0] row, input logic [1:0] col);
        coeff = row[COEF_W*col +: COEF_W];
    endfunction

endpackage

@@ sv/cbfc_if.sv @@
// Valid/ready channel interfaces for chunk requests and cull results.
// Depends on cbfc_pkg for field widths.
interface cbfc_req_if;
    import cbfc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [INDEX_W-1:0]         chunk_index;
    logic signed [COORD_W-1:0]  offset_x;
    logic signed [COORD_W-1:0]  offset_z;

    modport source (output valid, output chunk_index, output offset_x, output offset_z,
                    input ready);
    modport sink   (input valid, input chunk_index, input offset_x, input offset_z,
                    output ready);
endinterface

interface cbfc_rsp_if;
    import cbfc_pkg::*;

    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] chunk_index_out;
    logic               in_frustum;

    modport source (output valid, output chunk_index_out, output in_frustum, input ready);
    modport sink   (input valid, input chunk_index_out, input in_frustum, output ready);
endinterface

@@ sv/chunk_box_frustum_cull.sv @@
// Top level of the chunk box frustum cull block: config registers and six-stage pipeline.
// Depends on cbfc_pkg and the channel interfaces in cbfc_if.sv.
//
// Usage
//   req carries one chunk per transaction: grid index and world corner offset.
//   rsp returns one transaction per chunk, in order: the index and in_frustum,
//   which is 0 only when all eight box corners lie outside one clip plane.
//   The config port writes one register per cycle with cfg_we high; write only
//   while no chunk is in flight.
// Timing
//   A result shows on rsp after its chunk has passed all six register stages.
//   One chunk per cycle is sustained while rsp.ready is high; each stage holds one
//   chunk and moves whenever the stage after it is empty or moving, so bubbles
//   collapse and a chunk is taken while a result waits, if a stage is empty.
// Stall
//   With rsp.ready low the output holds; earlier stages keep filling until all
//   six are full, then req.ready drops. Nothing is lost or repeated.
// Reset
//   rst_n clears all stage valid bits and loads register defaults: matrix and
//   camera zero, chunk size 64, max height 256.
// Arithmetic
//   Corner clip values use linearity: base = M*(bx,0,bz,1), plus per-axis steps
//   M*size or M*height. All sums are exact at the common Q10 scale.
module chunk_box_frustum_cull (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  cbfc_pkg::cfg_reg_t        cfg_index,
    input  logic [cbfc_pkg::CFG_W-1:0] cfg_wdata,
    cbfc_req_if.sink                  req,
    cbfc_rsp_if.source                rsp
);
    import cbfc_pkg::*;

    localparam int STAGES = 6;

    // Configuration registers
    logic [ROW_W-1:0]          matrix_reg [ROWS];
    logic signed [COORD_W-1:0] camera_x_reg;
    logic signed [COORD_W-1:0] camera_z_reg;
    logic [SIZE_W-1:0]         chunk_size_reg;
    logic [SIZE_W-1:0]         max_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ROWS; r++)
                matrix_reg[r] <= '0;
            camera_x_reg   <= '0;
            camera_z_reg   <= '0;
            chunk_size_reg <= CHUNK_SIZE_RST;
            max_height_reg <= MAX_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MATRIX_ROW0: matrix_reg[0] <= cfg_wdata;
                REG_MATRIX_ROW1: matrix_reg[1] <= cfg_wdata;
                REG_MATRIX_ROW2: matrix_reg[2] <= cfg_wdata;
                REG_MATRIX_ROW3: matrix_reg[3] <= cfg_wdata;
                REG_CAMERA_X:    camera_x_reg   <= cfg_wdata[COORD_W-1:0];
                REG_CAMERA_Z:    camera_z_reg   <= cfg_wdata[COORD_W-1:0];
                REG_CHUNK_SIZE:  chunk_size_reg <= cfg_wdata[SIZE_W-1:0];
                REG_MAX_HEIGHT:  max_height_reg <= cfg_wdata[SIZE_W-1:0];
            endcase
        end
    end

    // Pipeline flow control: a stage advances when it is empty or its
    // successor advances; the last stage advances when rsp takes the result.
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] adv;

    always_comb
    begin
        adv[STAGES-1] = !valid_reg[STAGES-1] || rsp.ready;
        for (int s = STAGES - 2; s >= 0; s--)
            adv[s] = !valid_reg[s] || adv[s+1];
    end

    assign req.ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (adv[0])
                valid_reg[0] <= req.valid;
            for (int s = 1; s < STAGES; s++)
                if (adv[s])
                    valid_reg[s] <= valid_reg[s-1];
        end
    end

    // Stage 0: box origin relative to camera
    logic [INDEX_W-1:0]        idx0_reg;
    logic signed [BASE_W-1:0]  bx_reg;
    logic signed [BASE_W-1:0]  bz_reg;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            idx0_reg <= req.chunk_index;
            bx_reg   <= BASE_W'(req.offset_x) + BASE_W'(camera_x_reg);
            bz_reg   <= BASE_W'(req.offset_z) + BASE_W'(camera_z_reg);
        end
    end

    // Stage 1: per-row products
    logic [INDEX_W-1:0]        idx1_reg;
    logic signed [PROD_W-1:0]  px_reg [ROWS];
    logic signed [PROD_W-1:0]  pz_reg [ROWS];
    coef_t                     pw1_reg [ROWS];
    logic signed [STEP_W-1:0]  dx1_reg [ROWS];
    logic signed [STEP_W-1:0]  dy1_reg [ROWS];
    logic signed [STEP_W-1:0]  dz1_reg [ROWS];

    logic signed [SIZE_W:0]    size_s;
    logic signed [SIZE_W:0]    height_s;

    assign size_s   = $signed({1'b0, chunk_size_reg});
    assign height_s = $signed({1'b0, max_height_reg});

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            idx1_reg <= idx0_reg;
            for (int r = 0; r < ROWS; r++)
            begin
                px_reg[r]  <= PROD_W'(coeff(matrix_reg[r], 2'd0)) * PROD_W'(bx_reg);
                pz_reg[r]  <= PROD_W'(coeff(matrix_reg[r], 2'd2)) * PROD_W'(bz_reg);
                pw1_reg[r] <= coeff(matrix_reg[r], 2'd3);
                dx1_reg[r] <= STEP_W'(coeff(matrix_reg[r], 2'd0)) * STEP_W'(size_s);
                dy1_reg[r] <= STEP_W'(coeff(matrix_reg[r], 2'd1)) * STEP_W'(height_s);
                dz1_reg[r] <= STEP_W'(coeff(matrix_reg[r], 2'd2)) * STEP_W'(size_s);
            end
        end
    end

    // Stage 2: clip value of the low corner
    logic [INDEX_W-1:0]        idx2_reg;
    clip_t                     base_reg [ROWS];
    logic signed [STEP_W-1:0]  dx2_reg [ROWS];
    logic signed [STEP_W-1:0]  dy2_reg [ROWS];
    logic signed [STEP_W-1:0]  dz2_reg [ROWS];

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            idx2_reg <= idx1_reg;
            for (int r = 0; r < ROWS; r++)
            begin
                base_reg[r] <= CLIP_W'(px_reg[r]) + CLIP_W'(pz_reg[r]) + CLIP_W'(pw1_reg[r]);
                dx2_reg[r]  <= dx1_reg[r];
                dy2_reg[r]  <= dy1_reg[r];
                dz2_reg[r]  <= dz1_reg[r];
            end
        end
    end

    // Stage 3: partial sums, x step and the y/z step pair
    logic [INDEX_W-1:0] idx3_reg;
    clip_t              part_x_reg  [ROWS][AXIS_STEPS];
    clip_t              part_yz_reg [ROWS][AXIS_STEPS*AXIS_STEPS];

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            idx3_reg <= idx2_reg;
            for (int r = 0; r < ROWS; r++)
            begin
                part_x_reg[r][0] <= base_reg[r];
                part_x_reg[r][1] <= base_reg[r] + CLIP_W'(dx2_reg[r]);
                part_yz_reg[r][0] <= '0;
                part_yz_reg[r][1] <= CLIP_W'(dz2_reg[r]);
                part_yz_reg[r][2] <= CLIP_W'(dy2_reg[r]);
                part_yz_reg[r][3] <= CLIP_W'(dy2_reg[r]) + CLIP_W'(dz2_reg[r]);
            end
        end
    end

    // Stage 4: clip coordinates of all eight corners
    // corner bit 2 picks the x step, bit 1 the z step, bit 0 the y step
    logic [INDEX_W-1:0] idx4_reg;
    clip_t              clip_reg [ROWS][CORNERS];

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            idx4_reg <= idx3_reg;
            for (int r = 0; r < ROWS; r++)
                for (int n = 0; n < CORNERS; n++)
                    clip_reg[r][n] <= part_x_reg[r][n[2]] + part_yz_reg[r][{n[0], n[1]}];
        end
    end

    // Stage 5: plane tests and result register
    logic               culled;
    logic [INDEX_W-1:0] idx5_reg;
    logic               in_frustum_reg;

    always_comb
    begin
        logic signed [CMP_W-1:0] sum_lo;
        logic signed [CMP_W-1:0] sum_hi;
        logic                    all_below;
        logic                    all_above;
        culled = 1'b0;
        for (int a = 0; a < ROWS - 1; a++)
        begin
            all_below = 1'b1;
            all_above = 1'b1;
            for (int n = 0; n < CORNERS; n++)
            begin
                // c < -w  <=>  c + w < 0 ;  c > w  <=>  w - c < 0
                sum_lo = CMP_W'(clip_reg[a][n]) + CMP_W'(clip_reg[ROWS-1][n]);
                sum_hi = CMP_W'(clip_reg[ROWS-1][n]) - CMP_W'(clip_reg[a][n]);
                all_below = all_below & sum_lo[CMP_W-1];
                all_above = all_above & sum_hi[CMP_W-1];
            end
            culled = culled | all_below | all_above;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            idx5_reg       <= idx4_reg;
            in_frustum_reg <= !culled;
        end
    end

    assign rsp.valid           = valid_reg[STAGES-1];
    assign rsp.chunk_index_out = idx5_reg;
    assign rsp.in_frustum      = in_frustum_reg;

endmodule

@@ sv/cbfc_checker.sv @@
// Port-level checker for chunk_box_frustum_cull, bound to the top level.
// Depends on cbfc_pkg for field widths.
module cbfc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [cbfc_pkg::INDEX_W-1:0]  rsp_chunk_index_out,
    input logic                          rsp_in_frustum
);
    import cbfc_pkg::*;

    localparam int DEPTH = 6;

    logic [3:0] outstanding_reg;
    logic [3:0] outstanding_next;
    logic       req_take;
    logic       rsp_take;

    assign req_take = req_valid && req_ready;
    assign rsp_take = rsp_valid && rsp_ready;

    always_comb
    begin
        outstanding_next = outstanding_reg + 4'(req_take) - 4'(rsp_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            outstanding_reg <= '0;
        else
            outstanding_reg <= outstanding_next;
    end

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_chunk_index_out)
            && $stable(rsp_in_frustum))
        else $error("stalled result changed");

    // No result without an accepted chunk behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> outstanding_reg != 4'd0)
        else $error("result without a pending chunk");

    // The pipeline never holds more chunks than it has stages.
    assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= 4'(DEPTH))
        else $error("more chunks in flight than stages");

    // With the output empty every stage can advance, so any offered chunk is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("input blocked while output is empty");

endmodule

bind chunk_box_frustum_cull cbfc_checker u_cbfc_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .req_valid           (req.valid),
    .req_ready           (req.ready),
    .rsp_valid           (rsp.valid),
    .rsp_ready           (rsp.ready),
    .rsp_chunk_index_out (rsp.chunk_index_out),
    .rsp_in_frustum      (rsp.in_frustum)
);

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for chunk_box_frustum_cull: verdict predictor, stimulus and checks.
// Depends on cbfc_pkg (sv/cbfc_pkg.sv) and the channel interfaces (sv/cbfc_if.sv).
module testbench;
    import cbfc_pkg::*;

    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 163;
    localparam int QUIET_LIMIT   = 1000;  // cycles with no transaction before giving up
    localparam int DRAIN_CYCLES  = 12;    // pipeline is six stages deep

    // Flavors of random register setting.
    typedef enum int {
        SET_SMALL,        // small coefficients, camera near origin
        SET_WILD,         // every register bit random
        SET_PERSPECTIVE   // scaled diagonal with a w row taken from z
    } setting_style_t;

    typedef struct {
        logic [ROW_W-1:0]          mat [ROWS];
        logic signed [COORD_W-1:0] cam_x;
        logic signed [COORD_W-1:0] cam_z;
        logic [SIZE_W-1:0]         box_edge;
        logic [SIZE_W-1:0]         box_top;
    } cull_setting_t;

    typedef struct packed {
        logic [INDEX_W-1:0] chunk_index;
        logic               in_frustum;
    } cull_verdict_t;

    // Shadow copy of the registers, predictor of the in-frustum verdict and
    // the queue of verdicts still owed by the block.
    class cull_verdicts;
        logic [ROW_W-1:0]          mat [ROWS];
        logic signed [COORD_W-1:0] cam_x;
        logic signed [COORD_W-1:0] cam_z;
        logic [SIZE_W-1:0]         box_edge;
        logic [SIZE_W-1:0]         box_top;
        cull_verdict_t             pending_verdicts[$];
        int                        errors;
        int                        checked;
        int                        shown;
        int                        culled;

        function void load_defaults();
            foreach (mat[r])
                mat[r] = '0;
            cam_x    = '0;
            cam_z    = '0;
            box_edge = SIZE_W'(64);
            box_top  = SIZE_W'(256);
        endfunction

        function void write_reg(input cfg_reg_t r, input logic [CFG_W-1:0] v);
            case (r)
                REG_MATRIX_ROW0: mat[0] = v;
                REG_MATRIX_ROW1: mat[1] = v;
                REG_MATRIX_ROW2: mat[2] = v;
                REG_MATRIX_ROW3: mat[3] = v;
                REG_CAMERA_X:    cam_x = v[COORD_W-1:0];
                REG_CAMERA_Z:    cam_z = v[COORD_W-1:0];
                REG_CHUNK_SIZE:  box_edge = v[SIZE_W-1:0];
                REG_MAX_HEIGHT:  box_top = v[SIZE_W-1:0];
                default: ;
            endcase
        endfunction

        // Transform all eight corners exactly; cull only when every corner
        // falls outside one and the same clip plane.
        function bit box_may_show(input logic signed [COORD_W-1:0] ox,
                                  input logic signed [COORD_W-1:0] oz);
            longint corner [ROWS];
            longint clip [ROWS];
            int     below [3];
            int     above [3];
            bit     gone;
            gone = 1'b0;
            foreach (below[a])
            begin
                below[a] = 0;
                above[a] = 0;
            end
            for (int i = 0; i < AXIS_STEPS; i++)
                for (int j = 0; j < AXIS_STEPS; j++)
                    for (int k = 0; k < AXIS_STEPS; k++)
                    begin
                        corner[0] = longint'(ox) + longint'(cam_x) + i * longint'(box_edge);
                        corner[1] = k * longint'(box_top);
                        corner[2] = longint'(oz) + longint'(cam_z) + j * longint'(box_edge);
                        corner[3] = 1;
                        for (int r = 0; r < ROWS; r++)
                        begin
                            clip[r] = 0;
                            for (int c = 0; c < ROWS; c++)
                                clip[r] += longint'($signed(mat[r][COEF_W*c +: COEF_W]))
                                           * corner[c];
                        end
                        for (int a = 0; a < 3; a++)
                        begin
                            if (clip[a] < -clip[3])
                                below[a]++;
                            if (clip[a] > clip[3])
                                above[a]++;
                        end
                    end
            for (int a = 0; a < 3; a++)
                if (below[a] == CORNERS || above[a] == CORNERS)
                    gone = 1'b1;
            return !gone;
        endfunction

        function void note_chunk(input logic [INDEX_W-1:0] idx,
                                 input logic signed [COORD_W-1:0] ox,
                                 input logic signed [COORD_W-1:0] oz);
            cull_verdict_t v;
            v.chunk_index = idx;
            v.in_frustum  = box_may_show(ox, oz);
            pending_verdicts.push_back(v);
        endfunction

        function void check_verdict(input logic [INDEX_W-1:0] idx, input logic vis);
            cull_verdict_t want;
            if (pending_verdicts.size() == 0)
            begin
                $error("result with none expected: chunk_index_out %0d, in_frustum %0b",
                       idx, vis);
                errors++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (idx !== want.chunk_index)
                begin
                    $error("chunk_index_out mismatch: expected %0d, actual %0d",
                           want.chunk_index, idx);
                    errors++;
                end
                if (vis !== want.in_frustum)
                begin
                    $error("in_frustum mismatch (chunk %0d): expected %0b, actual %0b",
                           want.chunk_index, want.in_frustum, vis);
                    errors++;
                end
                checked++;
                if (want.in_frustum)
                    shown++;
                else
                    culled++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    cfg_reg_t           cfg_index;
    logic [CFG_W-1:0]   cfg_wdata;
    bit                 idle_on;
    int                 quiet_cycles;
    int                 settings_seen;
    cull_verdicts       verdicts;

    cbfc_req_if req_ch();
    cbfc_rsp_if rsp_ch();

    chunk_box_frustum_cull DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sample both channels at the edge, before any of this edge's updates land,
    // so a transaction is seen exactly as the block saw it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                verdicts.note_chunk(req_ch.chunk_index, req_ch.offset_x, req_ch.offset_z);
            if (rsp_ch.valid && rsp_ch.ready)
                verdicts.check_verdict(rsp_ch.chunk_index_out, rsp_ch.in_frustum);
        end
    end

    // Watchdog: abort when neither channel nor the config port moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (req_ch.valid && req_ch.ready)
            || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Result side: hold ready high, drop it in random bursts while idling is on.
    // A burst that lasts until all stages are full pushes back on req.
    initial
    begin
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // Offer one chunk and hold it until the block takes it. Call right after an
    // edge; returns right after the accepting edge, so back-to-back calls keep
    // valid high without a gap while idling is off.
    task automatic send_chunk(input logic [INDEX_W-1:0] idx,
                              input logic signed [COORD_W-1:0] ox,
                              input logic signed [COORD_W-1:0] oz);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.chunk_index <= idx;
        req_ch.offset_x    <= ox;
        req_ch.offset_z    <= oz;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [CFG_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_wdata <= v;
        @(posedge clk);
        verdicts.write_reg(r, v);
    endtask

    // Write every register back to back; junk fills the bits above narrow
    // registers, which the block must drop.
    task automatic apply_setting(input cull_setting_t s, input logic [CFG_W-1:0] junk);
        write_reg(REG_MATRIX_ROW0, s.mat[0]);
        write_reg(REG_MATRIX_ROW1, s.mat[1]);
        write_reg(REG_MATRIX_ROW2, s.mat[2]);
        write_reg(REG_MATRIX_ROW3, s.mat[3]);
        write_reg(REG_CAMERA_X, {junk[CFG_W-1:COORD_W], s.cam_x});
        write_reg(REG_CAMERA_Z, {junk[CFG_W-1:COORD_W], s.cam_z});
        write_reg(REG_CHUNK_SIZE, {junk[CFG_W-1:SIZE_W], s.box_edge});
        write_reg(REG_MAX_HEIGHT, {junk[CFG_W-1:SIZE_W], s.box_top});
        cfg_we <= 1'b0;
        settings_seen++;
    endtask

    // Drop valid, wait for every owed verdict, then let the pipeline empty.
    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (verdicts.pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic cull_setting_t identity_setting();
        cull_setting_t s;
        foreach (s.mat[r])
        begin
            s.mat[r] = '0;
            s.mat[r][COEF_W*r +: COEF_W] = 16'h0400;  // 1.0 in Q5.10
        end
        s.cam_x    = '0;
        s.cam_z    = '0;
        s.box_edge = SIZE_W'(64);
        s.box_top  = SIZE_W'(256);
        return s;
    endfunction

    function automatic logic [COEF_W-1:0] small_coef();
        return COEF_W'(int'($urandom_range(0, 4096)) - 2048);  // within +-2.0
    endfunction

    function automatic cull_setting_t random_setting(input setting_style_t style);
        cull_setting_t s;
        s = identity_setting();
        case (style)
            SET_SMALL:
            begin
                foreach (s.mat[r])
                    for (int c = 0; c < ROWS; c++)
                        s.mat[r][COEF_W*c +: COEF_W] = small_coef();
                s.cam_x    = COORD_W'(int'($urandom_range(0, 4095)) - 2048);
                s.cam_z    = COORD_W'(int'($urandom_range(0, 4095)) - 2048);
                s.box_edge = SIZE_W'($urandom_range(1, 256));
                s.box_top  = SIZE_W'($urandom_range(0, 1024));
            end
            SET_WILD:
            begin
                foreach (s.mat[r])
                    s.mat[r] = {$urandom, $urandom};
                s.cam_x    = COORD_W'($urandom);
                s.cam_z    = COORD_W'($urandom);
                s.box_edge = SIZE_W'($urandom);
                s.box_top  = SIZE_W'($urandom);
            end
            default:
            begin
                // x and y scaled by random factors, z biased, w follows z
                s.mat[0][0 +: COEF_W]        = COEF_W'($urandom_range(256, 4096));
                s.mat[1][COEF_W +: COEF_W]   = COEF_W'($urandom_range(256, 4096));
                s.mat[1][3*COEF_W +: COEF_W] = small_coef();
                s.mat[2][2*COEF_W +: COEF_W] = small_coef();
                s.mat[2][3*COEF_W +: COEF_W] = small_coef();
                s.mat[3]                     = '0;
                s.mat[3][2*COEF_W +: COEF_W] = 16'h0400;
                s.mat[3][3*COEF_W +: COEF_W] = small_coef();
                s.cam_x    = COORD_W'(int'($urandom_range(0, 4095)) - 2048);
                s.cam_z    = COORD_W'(int'($urandom_range(0, 4095)) - 2048);
                s.box_edge = ($urandom_range(0, 15) == 0) ? 16'hFFFF
                                                           : SIZE_W'($urandom_range(1, 128));
                s.box_top  = SIZE_W'($urandom_range(0, 512));
            end
        endcase
        return s;
    endfunction

    // One random phase: fresh register setting, then a stream of chunks whose
    // offsets mostly sit near the camera so both verdicts come up often.
    task automatic run_random_phase(input setting_style_t style, input int count,
                                    input bit idle);
        cull_setting_t             s;
        logic signed [COORD_W-1:0] ox;
        logic signed [COORD_W-1:0] oz;
        settle();
        s = random_setting(style);
        apply_setting(s, {$urandom, $urandom});
        idle_on = idle;
        for (int n = 0; n < count; n++)
        begin
            if (style == SET_WILD || $urandom_range(0, 3) == 0)
            begin
                ox = COORD_W'($urandom);
                oz = COORD_W'($urandom);
            end
            else
            begin
                ox = COORD_W'(int'($urandom_range(0, 8191)) - 4096);
                oz = COORD_W'(int'($urandom_range(0, 8191)) - 4096);
            end
            send_chunk(INDEX_W'($urandom), ox, oz);
        end
    endtask

    initial
    begin : stimulus
        cull_setting_t s;
        verdicts = new();
        verdicts.load_defaults();
        idle_on       = 1'b0;
        settings_seen = 1;
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= REG_MATRIX_ROW0;
        cfg_wdata          <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.chunk_index <= '0;
        req_ch.offset_x    <= '0;
        req_ch.offset_z    <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: a zero matrix puts every corner on every plane, so
        // nothing is ever culled. Push the field extremes through.
        send_chunk(12'd0, 24'sh800000, 24'sh800000);
        send_chunk(12'd4095, 24'sh7FFFFF, 24'sh7FFFFF);
        send_chunk(12'hAAA, 24'sh000000, 24'sh000000);
        send_chunk(12'h555, -24'sd1, 24'sd1);

        // Identity matrix, w = 1: hit each side of the x and z planes, and the
        // exact-boundary corners that must not count as outside.
        settle();
        s = identity_setting();
        apply_setting(s, '0);
        send_chunk(12'd1, 24'sd10, 24'sd0);      // right of x plane
        send_chunk(12'd2, -24'sd100, 24'sd0);    // left of x plane
        send_chunk(12'd3, 24'sd0, 24'sd10);      // beyond far z plane
        send_chunk(12'd4, 24'sd0, -24'sd100);    // behind near z plane
        send_chunk(12'd5, -24'sd32, -24'sd32);   // straddles the origin
        send_chunk(12'd6, -24'sd64, 24'sd0);
        send_chunk(12'd7, -24'sd65, 24'sd0);     // far corner exactly at -w
        send_chunk(12'd8, 24'sd1, 24'sd0);       // near corner exactly at w
        send_chunk(12'd9, 24'sd2, 24'sd2);

        // y biased up by 4.0: every corner above the top plane. Camera at its
        // extremes, junk in the upper bits of the narrow registers.
        settle();
        s = identity_setting();
        s.mat[1] = 64'h1000_0000_0400_0000;
        s.cam_x  = 24'sh800000;
        s.cam_z  = 24'sh7FFFFF;
        apply_setting(s, 64'hDEAD_BEEF_0000_0000);
        send_chunk(12'd100, 24'sd0, 24'sd0);
        send_chunk(12'd101, 24'sh7FFFFF, 24'sh800000);

        // y negated and biased down: every corner below the bottom plane.
        settle();
        s = identity_setting();
        s.mat[1] = 64'hF000_0000_FC00_0000;
        apply_setting(s, '1);
        send_chunk(12'd102, 24'sd0, 24'sd0);
        send_chunk(12'd103, -24'sd5, 24'sd7);

        // Zero chunk size and zero height: the box shrinks to a point.
        settle();
        s = identity_setting();
        s.box_edge = '0;
        s.box_top  = '0;
        apply_setting(s, '1);
        send_chunk(12'd20, 24'sd2, 24'sd0);      // point right of x plane
        send_chunk(12'd21, 24'sd1, -24'sd1);     // point on two planes, kept
        send_chunk(12'd22, 24'sd0, -24'sd2);     // point behind z plane

        // Extreme coefficients, camera, size and height.
        settle();
        s.mat[0]   = 64'h7FFF_8000_7FFF_8000;
        s.mat[1]   = 64'h8000_7FFF_8000_7FFF;
        s.mat[2]   = 64'h7FFF_7FFF_7FFF_7FFF;
        s.mat[3]   = 64'h8000_8000_8000_8000;
        s.cam_x    = 24'sh7FFFFF;
        s.cam_z    = 24'sh800000;
        s.box_edge = 16'hFFFF;
        s.box_top  = 16'hFFFF;
        apply_setting(s, {$urandom, $urandom});
        send_chunk(12'd4095, 24'sh7FFFFF, 24'sh7FFFFF);
        send_chunk(12'd0, 24'sh800000, 24'sh800000);
        send_chunk(12'd2048, 24'sh7FFFFF, 24'sh800000);

        // Random part: rotate the setting flavors, idle at random in most
        // phases, and run the last phase with no idling at all.
        for (int p = 0; p < RANDOM_PHASES; p++)
            run_random_phase(setting_style_t'(p % 3), PHASE_ITEMS,
                             (p < RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0));

        settle();
        $display("Checked %0d chunk verdicts (%0d in frustum, %0d culled) under %0d settings.",
                 verdicts.checked, verdicts.shown, verdicts.culled, settings_seen);
        if (verdicts.errors == 0 && verdicts.pending_verdicts.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ chunk_box_frustum_cull.f @@
sv/cbfc_pkg.sv
sv/cbfc_if.sv
sv/chunk_box_frustum_cull.sv
sv/cbfc_checker.sv
dv/testbench.sv
